>>> hw/rtl/byte_search_engine_assert.svh
// assertion macros for the byte search engine
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef BYTE_SEARCH_ENGINE_ASSERT_SVH
`define BYTE_SEARCH_ENGINE_ASSERT_SVH

// same-cycle implication
`define BSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bse_pkg.sv
package bse_pkg;

  // lane and queue sizing
  localparam int unsigned LANES_DEF      = 16;
  localparam int unsigned LANES_MAX      = 16;
  localparam int unsigned FIFO_DEPTH_DEF = 2;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned OFF_W          = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_W         = 64;

  // configuration register indexes
  typedef enum logic {
    REG_NEEDLE = 1'b0,
    REG_MODE   = 1'b1
  } reg_idx_e;

  // search modes
  typedef enum logic {
    MODE_LENGTH = 1'b0,
    MODE_TERM   = 1'b1
  } search_mode_e;

  // input item
  typedef struct packed {
    logic [WORD_W-1:0] bytes_low;
    logic [WORD_W-1:0] bytes_high;
    logic [CNT_W-1:0]  valid_count;
    logic              end_of_buffer;
  } in_item_t;

  // result item
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] match_offset;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic             decided;
    logic             hit;
    logic [CNT_W-1:0] lane;
    logic [CNT_W-1:0] count;
    logic             last;
  } class_t;

endpackage

>>> hw/rtl/bse_front.sv
module bse_front
  import bse_pkg::*;
#(
  parameter int unsigned LANES = LANES_DEF
) (
  input  in_item_t     item_i,
  input  logic [7:0]   needle_i,
  input  search_mode_e mode_i,
  output class_t       class_o
);

  logic [2*WORD_W-1:0] data;
  logic [CNT_W-1:0]    cnt_sat;
  logic [LANES-1:0]    match_v;
  logic [LANES-1:0]    stop_v;

  assign data = {item_i.bytes_high, item_i.bytes_low};

  // clamp the valid count to the lane count
  assign cnt_sat = (item_i.valid_count > CNT_W'(LANES)) ? CNT_W'(LANES)
                                                        : item_i.valid_count;

  // per-lane compare against needle and terminator
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      match_v[i] = (CNT_W'(i) < cnt_sat) && (data[BYTE_W*i +: BYTE_W] == needle_i);
      stop_v[i]  = match_v[i] ||
                   ((CNT_W'(i) < cnt_sat) && (mode_i == MODE_TERM) &&
                    (data[BYTE_W*i +: BYTE_W] == '0));
    end
  end

  // priority encode the first deciding lane
  always_comb begin
    class_o.decided = |stop_v;
    class_o.lane    = '0;
    class_o.hit     = 1'b0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (stop_v[i]) begin
        class_o.lane = CNT_W'(i);
        class_o.hit  = match_v[i];
      end
    end
    class_o.count = cnt_sat;
    class_o.last  = item_i.end_of_buffer;
  end

endmodule

>>> hw/rtl/bse_fifo.sv
module bse_fifo
  import bse_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  class_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output class_t data_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  class_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/bse_back.sv
module bse_back
  import bse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  class_t    head_i,
  input  logic      head_empty_i,
  output logic      head_pop_o,
  output out_item_t out_item_o,
  output logic      empty_o,
  input  logic      pop_i
);

  `include "byte_search_engine_assert.svh"

  logic [OFF_W-1:0] offset_q, offset_d;
  logic             done_q, done_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             take;
  logic             res_valid;
  logic [OFF_W:0]   sum;
  logic [OFF_W-1:0] sat;

  // take the next classified item whenever the output slot frees up
  assign take       = !head_empty_i && (!out_valid_q || pop_i);
  assign head_pop_o = take;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // saturating offset add
  assign sum = {1'b0, offset_q} + (OFF_W+1)'(head_i.decided ? head_i.lane : head_i.count);
  assign sat = sum[OFF_W] ? '1 : sum[OFF_W-1:0];

  // search state and result generation
  always_comb begin
    offset_d  = offset_q;
    done_d    = done_q;
    res_valid = 1'b0;
    out_d     = out_q;
    if (take) begin
      if (done_q) begin
        // dropping the rest of a decided buffer
        if (head_i.last) begin
          offset_d = '0;
          done_d   = 1'b0;
        end
      end else if (head_i.decided) begin
        res_valid          = 1'b1;
        out_d.found        = head_i.hit;
        out_d.match_offset = head_i.hit ? sat : '0;
        if (head_i.last) begin
          offset_d = '0;
          done_d   = 1'b0;
        end else begin
          done_d = 1'b1;
        end
      end else begin
        offset_d = sat;
        if (head_i.last) begin
          res_valid          = 1'b1;
          out_d.found        = 1'b0;
          out_d.match_offset = '0;
          offset_d           = '0;
          done_d             = 1'b0;
        end
      end
    end
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= out_d;
    end
  end

  // checks
  `BSE_ASSERT_IMP(a_new_result_from_take, $rose(out_valid_q), $past(take),
                  "result appeared without a taken item")
  `BSE_ASSERT_IMP(a_miss_offset_zero, out_valid_q && !out_q.found,
                  out_q.match_offset == '0, "not-found result with nonzero offset")
  `BSE_ASSERT_NXT(a_last_clears_state, take && head_i.last,
                  (offset_q == '0) && !done_q, "buffer end did not clear search state")

endmodule

>>> hw/rtl/byte_search_engine.sv
// Byte search engine: finds the first byte equal to the needle register in a buffer
// streamed as items of up to 16 bytes (lane 0 first). In length mode a buffer ends in a
// single result (found plus offset, or not found on the item marked last); in terminator
// mode a zero byte also ends it without a match unless it equals the needle. Items after
// a decision are dropped up to the one marked last, and offsets saturate at 0xFFFFFFFF.
// One item is accepted per clock while the queue is not full; the front compares all lanes
// and priority-encodes the first deciding lane as the item is accepted, a two-entry queue
// follows, and the back updates the 32-bit running offset and registers each result in
// an output slot. Registers: needle at 0x0, search_mode at 0x4; write them only while idle.
module byte_search_engine
  import bse_pkg::*;
#(
  parameter int unsigned LANES      = LANES_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  // result output
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]   needle_q;
  search_mode_e mode_q;
  reg_idx_e     reg_idx;
  logic         cfg_wr;
  class_t       class_in;
  class_t       class_head;
  logic         head_empty;
  logic         head_pop;

  // configuration registers
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      mode_q   <= MODE_LENGTH;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NEEDLE: needle_q <= pwdata[7:0];
        REG_MODE:   mode_q   <= search_mode_e'(pwdata[0]);
        default:    ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_NEEDLE: prdata = {24'd0, needle_q};
      REG_MODE:   prdata = {31'd0, mode_q};
      default:    prdata = '0;
    endcase
  end

  // lane classification
  bse_front #(
    .LANES (LANES)
  ) u_front (
    .item_i   (in_item_i),
    .needle_i (needle_q),
    .mode_i   (mode_q),
    .class_o  (class_in)
  );

  // decoupling queue
  bse_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (class_in),
    .full_o  (full),
    .pop_i   (head_pop),
    .data_o  (class_head),
    .empty_o (head_empty)
  );

  // offset tracking and results
  bse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (class_head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .out_item_o   (out_item_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule
